FILE: hw/rtl/tcc_pkg.sv
// tcc_pkg: shared types and constants of the text console cursor block.
// Used by tcc_ctrl, tcc_datapath and text_console_cursor_top; no dependencies.
`default_nettype none

package tcc_pkg;

    // Result command codes (m_tuser)
    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Input operation codes (s_tuser)
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd30;

    typedef enum logic [2:0] {
        KIND_CLEAR,
        KIND_NEWLINE,
        KIND_TAB,
        KIND_BACKSPACE,
        KIND_CHAR
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch the input beat
        logic step;    // emit one result of the held item and move the cursor
        logic scroll;  // emit the scroll owed by a wrapping draw
        logic last;    // mark the emitted result as final
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  wrap;       // column + 1 reaches the line end
        logic  scroll_due; // row + 1 passes the last row
        logic  tab_stop;   // column + 1 is a multiple of the tab width
        logic  out_free;   // output register can take a beat this cycle
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcc_datapath.sv
// tcc_datapath: configuration, cursor and output registers of the console.
// Depends on tcc_pkg; driven by tcc_ctrl through tcc_pkg::cmd_t.
`default_nettype none

module tcc_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [7:0]      cfg_data,
    input  wire logic            op_in,
    input  wire logic [7:0]      char_in,
    input  wire tcc_pkg::cmd_t   cmd,
    output tcc_pkg::status_t     status,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           out_cmd,
    output logic [7:0]           out_glyph,
    output logic [7:0]           out_col,
    output logic [7:0]           out_row,
    output logic                 out_last
);

    logic [7:0] columns_reg, rows_reg;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    logic       op_reg;
    logic [7:0] char_reg;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_cmd_reg, out_cmd_next;
    logic [7:0] out_glyph_reg, out_glyph_next;
    logic [7:0] out_col_reg, out_col_next;
    logic [7:0] out_row_reg, out_row_next;
    logic       out_last_reg, out_last_next;

    logic [8:0] col_inc, row_inc;
    logic [7:0] nl_row;
    logic       emit;
    tcc_pkg::kind_t kind;

    always_comb
    begin
        if (op_reg == tcc_pkg::OP_CLEAR)
            kind = tcc_pkg::KIND_CLEAR;
        else if (char_reg == tcc_pkg::CH_NEWLINE)
            kind = tcc_pkg::KIND_NEWLINE;
        else if (char_reg == tcc_pkg::CH_TAB)
            kind = tcc_pkg::KIND_TAB;
        else if (char_reg == tcc_pkg::CH_BACKSPACE)
            kind = tcc_pkg::KIND_BACKSPACE;
        else
            kind = tcc_pkg::KIND_CHAR;
    end

    // Nine-bit steps so that a cursor left beyond a shrunk screen wraps at once
    assign col_inc = {1'b0, col_reg} + 9'd1;
    assign row_inc = {1'b0, row_reg} + 9'd1;
    assign nl_row  = (row_inc >= {1'b0, rows_reg})
                   ? ((rows_reg == 8'd0) ? 8'd0 : rows_reg - 8'd1)
                   : row_inc[7:0];

    assign status.kind       = kind;
    assign status.wrap       = (col_inc >= {1'b0, columns_reg});
    assign status.scroll_due = (row_inc >= {1'b0, rows_reg});
    assign status.tab_stop   = (col_inc[2:0] == 3'd0);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        emit           = 1'b0;
        out_cmd_next   = out_cmd_reg;
        out_glyph_next = out_glyph_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;

        if (cmd.step)
        begin
            out_cmd_next   = tcc_pkg::CMD_DRAW;
            out_glyph_next = tcc_pkg::CH_SPACE;
            out_col_next   = col_reg;
            out_row_next   = row_reg;
            unique case (kind)
                tcc_pkg::KIND_CLEAR:
                begin
                    emit           = 1'b1;
                    out_cmd_next   = tcc_pkg::CMD_CLEAR;
                    out_glyph_next = 8'd0;
                    out_col_next   = 8'd0;
                    out_row_next   = 8'd0;
                    col_next       = 8'd0;
                    row_next       = 8'd0;
                end
                tcc_pkg::KIND_NEWLINE:
                begin
                    emit           = status.scroll_due;
                    out_cmd_next   = tcc_pkg::CMD_SCROLL;
                    out_glyph_next = 8'd0;
                    out_col_next   = 8'd0;
                    out_row_next   = 8'd0;
                    col_next       = 8'd0;
                    row_next       = nl_row;
                end
                tcc_pkg::KIND_BACKSPACE:
                begin
                    emit = (col_reg != 8'd0);
                    if (col_reg != 8'd0)
                    begin
                        col_next     = col_reg - 8'd1;
                        out_col_next = col_reg - 8'd1;
                    end
                end
                tcc_pkg::KIND_TAB, tcc_pkg::KIND_CHAR:
                begin
                    emit = 1'b1;
                    if (kind == tcc_pkg::KIND_CHAR)
                        out_glyph_next = char_reg;
                    if (status.wrap)
                    begin
                        col_next = 8'd0;
                        row_next = nl_row;
                    end
                    else
                    begin
                        col_next = col_inc[7:0];
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else if (cmd.scroll)
        begin
            emit           = 1'b1;
            out_cmd_next   = tcc_pkg::CMD_SCROLL;
            out_glyph_next = 8'd0;
            out_col_next   = 8'd0;
            out_row_next   = 8'd0;
        end

        if (emit)
            out_last_next = cmd.last;

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg   <= tcc_pkg::COLUMNS_RESET;
            rows_reg      <= tcc_pkg::ROWS_RESET;
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == tcc_pkg::REG_COLUMNS)
                columns_reg <= cfg_data;
            if (cfg_we && cfg_index == tcc_pkg::REG_ROWS)
                rows_reg <= cfg_data;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_in;
            char_reg <= char_in;
        end
        out_cmd_reg   <= out_cmd_next;
        out_glyph_reg <= out_glyph_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_cmd   = out_cmd_reg;
    assign out_glyph = out_glyph_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcc_ctrl.sv
// tcc_ctrl: sequencer that steps one console item through its result beats.
// Depends on tcc_pkg; commands tcc_datapath.
`default_nettype none

module tcc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tcc_pkg::status_t  status,
    output tcc_pkg::cmd_t          cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL
    } state_t;

    state_t state_reg, state_next;
    logic   last;

    always_comb
    begin
        unique case (status.kind) inside
            tcc_pkg::KIND_CLEAR, tcc_pkg::KIND_NEWLINE, tcc_pkg::KIND_BACKSPACE:
                last = 1'b1;
            tcc_pkg::KIND_CHAR:
                last = !(status.wrap && status.scroll_due);
            tcc_pkg::KIND_TAB:
                last = status.wrap ? !status.scroll_due : status.tab_stop;
            default:
                last = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // advance only when the output register can take the beat
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    cmd.last = last;
                    if (last)
                        state_next = ST_IDLE;
                    else if (status.wrap && status.scroll_due)
                        state_next = ST_SCROLL;
                end
            end
            ST_SCROLL:
            begin
                if (status.out_free)
                begin
                    cmd.scroll = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_cursor_top.sv
// text_console_cursor_top: cursor tracker of a character-cell text console.
// Depends on tcc_pkg, tcc_ctrl and tcc_datapath.
//
//   channel  direction  signals                         beat contents
//   s_       in         s_tvalid s_tready s_tdata       one byte and its operation
//                       s_tuser
//   m_       out        m_tvalid m_tready m_tdata       one draw, scroll or clear
//                       m_tuser m_tlast
//   cfg_     in         cfg_we cfg_index cfg_data       columns (0) or rows (1)
//
// Sequencing: one item at a time. After the accept, the item yields one result
// beat per cycle while the single output register is free: a plain character
// one draw, a wrapping one that scrolls two, a tab its draws (+1 scroll), at
// most 9 beats. A silent newline or a backspace at column 0 yields none.
// Reset: cursor at home, 80 columns, 30 rows, output register empty.
// Stalls: m_tready low holds the pending beat and freezes the sequencer;
// the output register lets the next item in once the last beat is loaded.
`default_nettype none

module text_console_cursor_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] glyph, [15:8] column, [23:16] row
    output logic [1:0]       m_tuser,   // [1:0] command
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    tcc_pkg::cmd_t    cmd;
    tcc_pkg::status_t status;
    logic [7:0]       glyph, column, row;

    tcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_in     (s_tuser),
        .char_in   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cmd   (m_tuser),
        .out_glyph (glyph),
        .out_col   (column),
        .out_row   (row),
        .out_last  (m_tlast)
    );

    // Pack the result beat: glyph lowest, then column, then row
    assign m_tdata = {row, column, glyph};

    // While the sequencer waits for input, any beat still held is the last of its item
    a_idle_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("beat held while idle is not the final one of its item");

    // A scroll always closes its item
    a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == tcc_pkg::CMD_SCROLL) |-> m_tlast)
        else $error("scroll beat without tlast");

    // Scroll and clear carry no cell or glyph
    a_nondraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != tcc_pkg::CMD_DRAW) |-> (m_tdata == 24'd0))
        else $error("scroll or clear beat with non-zero data");

    // An accepted item closes the input until its work is done
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened straight after an accept");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for text_console_cursor_top.
// Depends on tcc_pkg and the RTL under hw/rtl; needs nothing else.
`timescale 1ns / 1ps

module tb_top;
    import tcc_pkg::*;

    localparam int TAB_WIDTH     = 8;
    localparam int MAX_BEATS     = 9;     // a tab: eight draws and a scroll
    localparam int SETTLE_CYCLES = 12;    // settling wait after the last owed command
    localparam int STALL_LIMIT   = 2000;  // quiet cycles before giving up
    localparam int LONG_HOLD     = 80;    // sink hold-off used to back up the block
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 32;

    // One command beat as the block presents it
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] glyph;
        logic [7:0] column;
        logic [7:0] row;
        logic       last;
    } console_cmd_t;

    // Directed script: a byte checked by the cursor model, a byte with its
    // single command typed in, or a register write
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic         sel;    // operation, or register index for ROW_CFG
        logic [7:0]   value;  // char code, or register value for ROW_CFG
        console_cmd_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tuser   = OP_PUT;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_COLUMNS;
    logic [7:0]  cfg_data  = 8'd0;

    // Cursor model state and geometry
    int unsigned  line_width;
    int unsigned  screen_height;
    int unsigned  cur_col;
    int unsigned  cur_row;
    console_cmd_t step_cmds[$];     // commands caused by the byte just accepted
    console_cmd_t pending_cmds[$];  // commands still owed by the block
    script_row_t  script[$];

    int mismatches;
    int bytes_in;
    int beats_out;
    int draws_out;
    int scrolls_out;
    int clears_out;
    int geometries;
    int hold_requests;
    int holds_done;
    int steady_left;

    text_console_cursor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Cursor model
    // ------------------------------------------------------------------

    // Append one command to the current byte's list, never more than the
    // worst case allows
    function automatic void note_cmd(logic [1:0] cmd, logic [7:0] glyph,
                                     int unsigned col, int unsigned row);
        console_cmd_t c;
        if (step_cmds.size() >= MAX_BEATS)
            return;
        c.command = cmd;
        c.glyph   = glyph;
        c.column  = col[7:0];
        c.row     = row[7:0];
        c.last    = 1'b0;
        step_cmds.push_back(c);
    endfunction

    // Go to column 0 of the next row; scroll and stay put past the bottom.
    // The row step is done wide so a row left beyond a shrunk screen scrolls.
    function automatic void line_break();
        cur_col = 0;
        if (cur_row + 1 >= screen_height)
        begin
            note_cmd(CMD_SCROLL, 8'd0, 0, 0);
            cur_row = (screen_height == 0) ? 0 : screen_height - 1;
        end
        else
        begin
            cur_row = cur_row + 1;
        end
    endfunction

    // Draw at the stored cursor as it is, then advance or wrap
    function automatic void draw_and_advance(logic [7:0] glyph);
        note_cmd(CMD_DRAW, glyph, cur_col, cur_row);
        if (cur_col + 1 >= line_width)
            line_break();
        else
            cur_col = cur_col + 1;
    endfunction

    function automatic void console_predict(logic op, logic [7:0] code);
        step_cmds.delete();
        if (op == OP_CLEAR)
        begin
            // the char code plays no part in a clear
            note_cmd(CMD_CLEAR, 8'd0, 0, 0);
            cur_col = 0;
            cur_row = 0;
        end
        else
        begin
            case (code)
                CH_NEWLINE:
                begin
                    line_break();
                end
                CH_TAB:
                begin
                    draw_and_advance(CH_SPACE);
                    while ((cur_col % TAB_WIDTH) != 0 && cur_col < line_width
                           && step_cmds.size() < MAX_BEATS)
                        draw_and_advance(CH_SPACE);
                end
                CH_BACKSPACE:
                begin
                    // silent at column 0
                    if (cur_col > 0)
                    begin
                        cur_col = cur_col - 1;
                        note_cmd(CMD_DRAW, CH_SPACE, cur_col, cur_row);
                    end
                end
                default:
                begin
                    draw_and_advance(code);
                end
            endcase
        end
        if (step_cmds.size() > 0)
            step_cmds[step_cmds.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // One line per mismatch; keep counting once the log is long enough
    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] beat %0d: %s got 0x%02h want 0x%02h",
                     $realtime, beats_out, what, got, want);
    endtask

    // Compare every accepted command beat with the oldest one owed
    always @(posedge clk)
    begin : beat_monitor
        console_cmd_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            beats_out++;
            case (m_tuser)
                CMD_DRAW:   draws_out++;
                CMD_SCROLL: scrolls_out++;
                CMD_CLEAR:  clears_out++;
                default:    ;
            endcase
            if (pending_cmds.size() == 0)
            begin
                report_mismatch("beat with nothing owed, command", {6'd0, m_tuser}, 8'd0);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (m_tuser !== want.command)
                    report_mismatch("command", {6'd0, m_tuser}, {6'd0, want.command});
                if (m_tdata[7:0] !== want.glyph)
                    report_mismatch("glyph", m_tdata[7:0], want.glyph);
                if (m_tdata[15:8] !== want.column)
                    report_mismatch("column", m_tdata[15:8], want.column);
                if (m_tdata[23:16] !== want.row)
                    report_mismatch("row", m_tdata[23:16], want.row);
                if (m_tlast !== want.last)
                    report_mismatch("last", {7'd0, m_tlast}, {7'd0, want.last});
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink pacing: short and long stalls, calm stretches, and on request
    // one long hold-off so the block backs up and drops s_tready
    // ------------------------------------------------------------------
    initial
    begin : sink_pacing
        int stall_left;
        int calm_left;
        int roll;
        stall_left = 0;
        calm_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && hold_requests != holds_done)
            begin
                holds_done++;
                stall_left = LONG_HOLD;
                calm_left  = 0;
            end
            else if (stall_left == 0 && calm_left == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    calm_left = $urandom_range(20, 60);
                else if (roll < 30)
                    stall_left = $urandom_range(1, 3);
                else if (roll < 34)
                    stall_left = $urandom_range(8, 25);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (calm_left > 0)
                    calm_left--;
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1)
                || (m_tvalid === 1'b1 && m_tready === 1'b1) || cfg_we === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: %0d cycles without a beat, %0d commands still owed",
                 STALL_LIMIT, pending_cmds.size());
        $display("text_console_cursor_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Mostly back to back or short gaps, now and then a long one; a
    // steady stretch forces back-to-back beats
    function automatic int pick_gap();
        int roll;
        if (steady_left > 0)
        begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            steady_left = $urandom_range(10, 20);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte, hold it until taken, then book what it owes.
    // Drop tvalid only when a gap follows so it is never toggled in one step.
    task automatic send_byte(input logic op, input logic [7:0] code, input bit typed,
                             input console_cmd_t want, input int gap);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= code;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        bytes_in++;
        console_predict(op, code);
        if (typed)
        begin
            pending_cmds.push_back(want);
        end
        else
        begin
            foreach (step_cmds[k])
                pending_cmds.push_back(step_cmds[k]);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait for every owed command, then let a silent byte finish as well
    task automatic wait_idle();
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller drops it after its last write
    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_COLUMNS)
            line_width = 32'(value);
        else
            screen_height = 32'(value);
    endtask

    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] lines);
        wait_idle();
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, lines);
        cfg_we <= 1'b0;
        geometries++;
    endtask

    function automatic logic [7:0] boundary_value();
        case ($urandom_range(0, 2))
            0:       return 8'd0;
            1:       return 8'd1;
            default: return 8'd255;
        endcase
    endfunction

    function automatic void add_row(row_kind_t kind, logic sel, logic [7:0] value,
                                    logic [1:0] w_cmd, logic [7:0] w_glyph,
                                    logic [7:0] w_col, logic [7:0] w_row);
        script_row_t r;
        r.kind         = kind;
        r.sel          = sel;
        r.value        = value;
        r.want.command = w_cmd;
        r.want.glyph   = w_glyph;
        r.want.column  = w_col;
        r.want.row     = w_row;
        r.want.last    = 1'b1;
        script.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int          gap;
        int          roll;
        bit          pause_after;
        logic        op;
        logic [7:0]  code;
        logic [7:0]  cols;
        logic [7:0]  lines;

        line_width    = 32'(COLUMNS_RESET);
        screen_height = 32'(ROWS_RESET);
        cur_col       = 0;
        cur_row       = 0;

        // Directed script. Typed rows owe a single command that follows
        // straight from the cursor position; the rest go through the model.
        //       kind         sel          value         cmd         glyph  col   row
        // after reset: 80 x 30, cursor at home
        add_row(ROW_TYPED,   OP_PUT,      8'h41,        CMD_DRAW,   8'h41, 8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_PUT,      8'h00,        CMD_DRAW,   8'h00, 8'd1, 8'd0);
        add_row(ROW_TYPED,   OP_PUT,      8'hFF,        CMD_DRAW,   8'hFF, 8'd2, 8'd0);
        add_row(ROW_TYPED,   OP_PUT,      CH_BACKSPACE, CMD_DRAW,   CH_SPACE, 8'd2, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_TAB,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_NEWLINE,   CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_BACKSPACE, CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_CLEAR,    8'hFF,        CMD_CLEAR,  8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_TAB,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_CLEAR,    CH_NEWLINE,   CMD_CLEAR,  8'd0,  8'd0, 8'd0);
        // one cell, one line: every draw wraps and scrolls
        add_row(ROW_CFG,     REG_COLUMNS, 8'd1,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_CFG,     REG_ROWS,    8'd1,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      8'h78,        CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_PUT,      CH_NEWLINE,   CMD_SCROLL, 8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_TAB,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        // zero geometry: each draw breaks the line, each newline scrolls
        add_row(ROW_CFG,     REG_COLUMNS, 8'd0,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_CFG,     REG_ROWS,    8'd0,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      8'h7A,        CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_PUT,      CH_NEWLINE,   CMD_SCROLL, 8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_BACKSPACE, CMD_DRAW,   8'd0,  8'd0, 8'd0);
        // widest screen, then shrink it under the cursor
        add_row(ROW_CFG,     REG_COLUMNS, 8'd255,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_CFG,     REG_ROWS,    8'd255,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_TAB,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_NEWLINE,   CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_TAB,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_CFG,     REG_COLUMNS, 8'd2,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      8'h71,        CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_CFG,     REG_ROWS,    8'd1,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_PUT,      CH_NEWLINE,   CMD_SCROLL, 8'd0,  8'd0, 8'd0);
        // eight columns on one line: a tab from home gives the worst case
        add_row(ROW_CFG,     REG_COLUMNS, 8'd8,         CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      CH_TAB,       CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_PREDICT, OP_PUT,      8'h80,        CMD_DRAW,   8'd0,  8'd0, 8'd0);
        add_row(ROW_TYPED,   OP_CLEAR,    8'h00,        CMD_CLEAR,  8'd0,  8'd0, 8'd0);

        // Hold reset, then release it once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the script; pause before every register write so the
        // block is idle when its geometry changes
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(script[i].sel, script[i].value);
                cfg_we <= 1'b0;
                geometries++;
            end
            else
            begin
                pause_after = (i + 1 == script.size()) || (script[i + 1].kind == ROW_CFG);
                gap = pick_gap();
                if (pause_after && gap == 0)
                    gap = 1;
                send_byte(script[i].sel, script[i].value, script[i].kind == ROW_TYPED,
                          script[i].want, gap);
            end
        end

        // Random phases, each under its own geometry. Small screens get
        // the largest share of the weight so wraps and scrolls come often.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
            begin
                cols  = 8'($urandom_range(1, 12));
                lines = 8'($urandom_range(1, 4));
            end
            else if (roll < 6)
            begin
                cols  = boundary_value();
                lines = boundary_value();
            end
            else if (roll < 8)
            begin
                cols  = COLUMNS_RESET;
                lines = ROWS_RESET;
            end
            else
            begin
                cols  = 8'($urandom_range(0, 255));
                lines = 8'($urandom_range(0, 255));
            end
            set_geometry(cols, lines);

            for (int n = 0; n < PHASE_BYTES; n++)
            begin
                // Twice in the run: let the sink sit on its ready for a
                // long stretch while the source keeps offering beats
                if ((phase == 1 || phase == 4) && n == 4)
                begin
                    hold_requests++;
                    steady_left = 20;
                end
                op   = OP_PUT;
                roll = $urandom_range(0, 99);
                if (roll < 4)
                begin
                    op   = OP_CLEAR;
                    code = 8'($urandom_range(0, 255));
                end
                else if (roll < 18)
                    code = CH_NEWLINE;
                else if (roll < 36)
                    code = CH_TAB;
                else if (roll < 50)
                    code = CH_BACKSPACE;
                else if (roll < 58)
                    code = 8'($urandom_range(0, 15));
                else
                    code = 8'($urandom_range(0, 255));
                gap = pick_gap();
                if (n == PHASE_BYTES - 1 && gap == 0)
                    gap = 1;
                send_byte(op, code, 1'b0, '0, gap);
            end
        end

        // Drain: everything owed, then a settling wait for a trailing silent byte
        wait_idle();

        $display("covered %0d bytes under %0d geometries: %0d draws, %0d scrolls, %0d clears",
                 bytes_in, geometries, draws_out, scrolls_out, clears_out);
        $display("sink held off %0d times; %0d beats checked, %0d mismatches",
                 holds_done, beats_out, mismatches);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("text_console_cursor_top: match");
        else
            $display("text_console_cursor_top: mismatch");
        $finish;
    end

endmodule
